[rtl/zac_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zac_pkg
// Opcodes, field widths and shared types of the ALU and compare unit.
// ----------------------------------------------------------------------------
package zac_pkg;

  localparam int W = 16;
  localparam int OpBits = 4;
  localparam int CntBits = 3;

  localparam logic [OpBits-1:0] OP_ADD    = 4'd0;
  localparam logic [OpBits-1:0] OP_SUB    = 4'd1;
  localparam logic [OpBits-1:0] OP_MUL    = 4'd2;
  localparam logic [OpBits-1:0] OP_DIV    = 4'd3;
  localparam logic [OpBits-1:0] OP_REM    = 4'd4;
  localparam logic [OpBits-1:0] OP_SHIFT  = 4'd5;
  localparam logic [OpBits-1:0] OP_ASHIFT = 4'd6;
  localparam logic [OpBits-1:0] OP_OR     = 4'd7;
  localparam logic [OpBits-1:0] OP_NOT    = 4'd8;
  localparam logic [OpBits-1:0] OP_AND    = 4'd9;
  localparam logic [OpBits-1:0] OP_TEST   = 4'd10;
  localparam logic [OpBits-1:0] OP_JZ     = 4'd11;
  localparam logic [OpBits-1:0] OP_JE     = 4'd12;
  localparam logic [OpBits-1:0] OP_JL     = 4'd13;
  localparam logic [OpBits-1:0] OP_JG     = 4'd14;

  typedef struct packed {
    logic [OpBits-1:0] op;
    logic [W-1:0] operand_a;
    logic [W-1:0] operand_b;
    logic [W-1:0] operand_c;
    logic [W-1:0] operand_d;
    logic [CntBits-1:0] operand_count;
  } in_t;

  typedef struct packed {
    logic [W-1:0] store_value;
    logic is_branch;
    logic branch_taken;
    logic divide_by_zero;
  } out_t;

  // Result of one ALU lane that does not need the divider
  typedef struct packed {
    logic [W-1:0] value;
    logic is_branch;
    logic taken;
  } fast_t;

endpackage
`default_nettype wire

[rtl/zac_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zac_in_if / zac_out_if
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
interface zac_in_if;
  logic valid;
  logic ready;
  zac_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface zac_out_if;
  logic valid;
  logic ready;
  zac_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/zac_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zac_divider
// Pipelined restoring divider on magnitudes: STEPS quotient bits per stage,
// one stage per register. Advances only when en is high.
// ----------------------------------------------------------------------------
module zac_divider #(
  parameter int STAGES = 4
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [zac_pkg::W-1:0] num,
  input  wire logic [zac_pkg::W-1:0] den,
  output logic [zac_pkg::W-1:0] quo,
  output logic [zac_pkg::W-1:0] rem
);
  localparam int W = zac_pkg::W;
  localparam int STEPS = W / STAGES;

  logic [W-1:0] q [STAGES+1];
  logic [W-1:0] r [STAGES+1];
  logic [W-1:0] d [STAGES+1];

  assign q[0] = num;
  assign r[0] = '0;
  assign d[0] = den;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [W-1:0] qn, rn;
    // Shift in STEPS dividend bits, subtracting where the divisor fits
    always_comb begin
      logic [W:0] t;
      qn = q[s];
      rn = r[s];
      for (int k = 0; k < STEPS; k++) begin
        t = {rn, qn[W-1]};
        qn = {qn[W-2:0], 1'b0};
        if (t >= {1'b0, d[s]}) begin
          t = t - {1'b0, d[s]};
          qn[0] = 1'b1;
        end
        rn = t[W-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q[s+1] <= qn;
        r[s+1] <= rn;
        d[s+1] <= d[s];
      end
    end
  end

  assign quo = q[STAGES];
  assign rem = r[STAGES];
endmodule
`default_nettype wire

[rtl/zmachine_alu_and_compare.sv]
`timescale 1ns / 1ps
`default_nettype none
// Registers from input beat to result: entry, 4 divider stages, result; one
//   beat per cycle sustained while the output is not stalled.
// The multiplier product is registered in the entry stage, sign fixups in the
//   last stage. A stall freezes the whole pipe; the output register holds.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// zmachine_alu_and_compare
// Sixteen-bit ALU and branch compare unit, fully pipelined.
// ----------------------------------------------------------------------------
module zmachine_alu_and_compare #(
  parameter int MAX_OPERANDS = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  zac_in_if.sink in_ch,
  zac_out_if.source out_ch
);
  localparam int W = zac_pkg::W;
  localparam int DSTG = 4;
  localparam int NV = DSTG + 2;
  // Highest operand count that equal-to-any looks at
  localparam logic [2:0] CNT_MAX = (MAX_OPERANDS < 4) ? 3'(MAX_OPERANDS) : 3'd4;

  // Pipe advances when the output register is free or being drained
  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  logic [NV-1:0] vld;

  // Side-band carried alongside the divider
  typedef struct packed {
    zac_pkg::fast_t f;
    logic [W-1:0] prod;
    logic is_div;
    logic is_rem;
    logic dz;
    logic neg_q;
    logic neg_r;
  } side_t;

  side_t side [DSTG+1];

  // Entry stage combinational work
  zac_pkg::in_t x;
  zac_pkg::fast_t f;
  logic [W-1:0] ma, mb;
  assign x = in_ch.data;
  assign ma = x.operand_a[W-1] ? W'(-x.operand_a) : x.operand_a;
  assign mb = x.operand_b[W-1] ? W'(-x.operand_b) : x.operand_b;

  always_comb begin
    logic [W-1:0] a, b, nb;
    logic [2:0] cnt;
    logic lt, gt;
    a = x.operand_a;
    b = x.operand_b;
    nb = W'(-b);
    cnt = x.operand_count;
    if (cnt > CNT_MAX) cnt = CNT_MAX;
    lt = $signed(a) < $signed(b);
    gt = $signed(a) > $signed(b);
    f = '0;
    case (x.op)
      zac_pkg::OP_ADD: f.value = a + b;
      zac_pkg::OP_SUB: f.value = a - b;
      zac_pkg::OP_SHIFT, zac_pkg::OP_ASHIFT: begin
        if (!b[W-1]) begin
          f.value = (b >= W'(W)) ? '0 : a << b[3:0];
        end else if (nb >= W'(W) || nb == '0) begin
          f.value = (x.op == zac_pkg::OP_ASHIFT && a[W-1]) ? '1 : '0;
        end else if (x.op == zac_pkg::OP_ASHIFT) begin
          f.value = W'($signed(a) >>> nb[3:0]);
        end else begin
          f.value = a >> nb[3:0];
        end
      end
      zac_pkg::OP_OR: f.value = a | b;
      zac_pkg::OP_NOT: f.value = ~a;
      zac_pkg::OP_AND: f.value = a & b;
      zac_pkg::OP_TEST: begin
        f.is_branch = 1'b1;
        f.taken = (~a & b) == '0;
      end
      zac_pkg::OP_JZ: begin
        f.is_branch = 1'b1;
        f.taken = a == '0;
      end
      zac_pkg::OP_JE: begin
        f.is_branch = 1'b1;
        f.taken = (cnt >= 3'd2 && x.operand_b == a) ||
                  (cnt >= 3'd3 && x.operand_c == a) ||
                  (cnt >= 3'd4 && x.operand_d == a);
      end
      zac_pkg::OP_JL: begin
        f.is_branch = 1'b1;
        f.taken = lt;
      end
      zac_pkg::OP_JG: begin
        f.is_branch = 1'b1;
        f.taken = gt;
      end
      default: f = '0;
    endcase
  end

  // Register entry stage: fast result, product, divider signs
  logic [W-1:0] num0, den0;
  always_ff @(posedge clk) begin
    if (adv) begin
      side[0].f <= f;
      side[0].prod <= W'(x.operand_a * x.operand_b);
      side[0].is_div <= x.op == zac_pkg::OP_DIV;
      side[0].is_rem <= x.op == zac_pkg::OP_REM;
      side[0].dz <= (x.op == zac_pkg::OP_DIV || x.op == zac_pkg::OP_REM) &&
                    x.operand_b == '0;
      side[0].neg_q <= x.operand_a[W-1] ^ x.operand_b[W-1];
      side[0].neg_r <= x.operand_a[W-1];
      num0 <= ma;
      den0 <= mb;
    end
  end

  logic is_mul0;
  always_ff @(posedge clk) begin
    if (adv) is_mul0 <= x.op == zac_pkg::OP_MUL;
  end
  logic is_mul [DSTG+1];
  assign is_mul[0] = is_mul0;

  for (genvar s = 0; s < DSTG; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        side[s+1] <= side[s];
        is_mul[s+1] <= is_mul[s];
      end
    end
  end

  logic [W-1:0] quo, rmd;
  zac_divider #(.STAGES(DSTG)) u_div (
    .clk(clk), .en(adv), .num(num0), .den(den0), .quo(quo), .rem(rmd)
  );

  // Final stage: select result and apply signs
  zac_pkg::out_t res;
  side_t sl;
  assign sl = side[DSTG];
  always_comb begin
    res = '0;
    res.is_branch = sl.f.is_branch;
    res.branch_taken = sl.f.taken;
    res.store_value = sl.f.value;
    if (is_mul[DSTG]) res.store_value = sl.prod;
    if (sl.is_div || sl.is_rem) begin
      res.divide_by_zero = sl.dz;
      if (sl.dz) res.store_value = '0;
      else if (sl.is_div) res.store_value = sl.neg_q ? W'(-quo) : quo;
      else res.store_value = sl.neg_r ? W'(-rmd) : rmd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_ch.data <= res;
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NV-2:0], in_ch.valid};
    end
  end
  assign out_ch.valid = vld[NV-1];

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  // A zero-divisor result carries a zero store value and is no branch
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.divide_by_zero |->
      out_ch.data.store_value == '0 && !out_ch.data.is_branch)
    else $error("bad zero-divisor result");
  // Ready follows the output register only
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("ready mismatch");
endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives instruction beats with random gaps into the ALU and compare unit and
// checks every result beat against a word-level model of each opcode.
// ----------------------------------------------------------------------------
module testbench;
  import zac_pkg::*;

  localparam int MaxOperands = 4;
  localparam int RandomBeats = 800;
  localparam int CycleLimit = 200000;
  localparam logic [OpBits-1:0] OP_UNUSED = 4'd15;

  typedef struct {
    in_t instr;
    logic check_row;
    out_t row_result;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int cycles = 0;
  int errors = 0;
  logic stim_done = 1'b0;
  out_t pending_results[$];

  zac_in_if in_ch ();
  zac_out_if out_ch ();

  zmachine_alu_and_compare #(.MAX_OPERANDS(MaxOperands)) uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Guard against a hung pipe
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** zmachine_alu_and_compare: FAILED **");
      $finish;
    end
  end

  function automatic logic [W-1:0] neg_word(logic [W-1:0] v);
    return ~v + 1'b1;
  endfunction

  function automatic logic [W-1:0] signed_shift(logic [W-1:0] a, logic [W-1:0] b,
                                                logic arith);
    logic [W-1:0] n;
    logic fill;
    fill = arith && a[W-1];
    if (b == 0) return a;
    if (!b[W-1]) return (b >= W) ? '0 : a << b;
    n = neg_word(b);
    if (n >= W) return fill ? '1 : '0;
    return fill ? ~((~a) >> n) : a >> n;
  endfunction

  function automatic out_t alu_result(in_t x);
    out_t r;
    logic [W-1:0] ma, mb, q, rm;
    int n;
    r = '0;
    case (x.op)
      OP_ADD: r.store_value = x.operand_a + x.operand_b;
      OP_SUB: r.store_value = x.operand_a - x.operand_b;
      OP_MUL: r.store_value = x.operand_a * x.operand_b;
      OP_DIV, OP_REM: begin
        if (x.operand_b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          ma = x.operand_a[W-1] ? neg_word(x.operand_a) : x.operand_a;
          mb = x.operand_b[W-1] ? neg_word(x.operand_b) : x.operand_b;
          q = ma / mb;
          rm = ma % mb;
          if (x.op == OP_DIV)
            r.store_value = (x.operand_a[W-1] ^ x.operand_b[W-1]) ? neg_word(q) : q;
          else
            r.store_value = x.operand_a[W-1] ? neg_word(rm) : rm;
        end
      end
      OP_SHIFT: r.store_value = signed_shift(x.operand_a, x.operand_b, 1'b0);
      OP_ASHIFT: r.store_value = signed_shift(x.operand_a, x.operand_b, 1'b1);
      OP_OR: r.store_value = x.operand_a | x.operand_b;
      OP_NOT: r.store_value = ~x.operand_a;
      OP_AND: r.store_value = x.operand_a & x.operand_b;
      OP_TEST: begin
        r.is_branch = 1'b1;
        r.branch_taken = (~x.operand_a & x.operand_b) == 0;
      end
      OP_JZ: begin
        r.is_branch = 1'b1;
        r.branch_taken = x.operand_a == 0;
      end
      OP_JE: begin
        r.is_branch = 1'b1;
        n = x.operand_count;
        if (n > 4) n = 4;
        if (n > MaxOperands) n = MaxOperands;
        if (n > 1 && x.operand_b == x.operand_a) r.branch_taken = 1'b1;
        if (n > 2 && x.operand_c == x.operand_a) r.branch_taken = 1'b1;
        if (n > 3 && x.operand_d == x.operand_a) r.branch_taken = 1'b1;
      end
      OP_JL: begin
        r.is_branch = 1'b1;
        r.branch_taken = $signed(x.operand_a) < $signed(x.operand_b);
      end
      OP_JG: begin
        r.is_branch = 1'b1;
        r.branch_taken = $signed(x.operand_a) > $signed(x.operand_b);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic in_t make_instr(logic [OpBits-1:0] op, logic [W-1:0] a,
                                     logic [W-1:0] b, logic [W-1:0] c,
                                     logic [W-1:0] d, logic [CntBits-1:0] n);
    in_t x;
    x.op = op;
    x.operand_a = a;
    x.operand_b = b;
    x.operand_c = c;
    x.operand_d = d;
    x.operand_count = n;
    return x;
  endfunction

  function automatic logic [W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      3: return 16'h7fff;
      4: return W'($urandom_range(0, 20));
      5: return neg_word(W'($urandom_range(0, 20)));
      default: return W'($urandom);
    endcase
  endfunction

  // Send one beat and queue its prediction; valid stays high into a gapless beat
  task automatic send_beat(in_t x);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= x;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(alu_result(x));
  endtask

  // Receiver: random stalls, compare every result beat
  initial begin
    out_t got, want;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: store_value %h", got.store_value);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.store_value !== want.store_value) begin
          $error("store_value: expected %h, got %h", want.store_value, got.store_value);
          errors++;
        end
        if (got.is_branch !== want.is_branch) begin
          $error("is_branch: expected %b, got %b", want.is_branch, got.is_branch);
          errors++;
        end
        if (got.branch_taken !== want.branch_taken) begin
          $error("branch_taken: expected %b, got %b", want.branch_taken,
                 got.branch_taken);
          errors++;
        end
        if (got.divide_by_zero !== want.divide_by_zero) begin
          $error("divide_by_zero: expected %b, got %b", want.divide_by_zero,
                 got.divide_by_zero);
          errors++;
        end
      end
    end
  end

  // Stimulus: directed table, then random beats
  initial begin
    row_t rows[$];
    row_t row;
    in_t x;
    out_t known;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    known = '0;
    known.divide_by_zero = 1'b1;
    rows.push_back('{make_instr(OP_DIV, 16'h1234, 0, 0, 0, 2), 1'b1, known});
    rows.push_back('{make_instr(OP_REM, 16'hffff, 0, 0, 0, 2), 1'b1, known});
    known = '0;
    known.store_value = 16'h8000;
    rows.push_back('{make_instr(OP_DIV, 16'h8000, 16'hffff, 0, 0, 2), 1'b1, known});
    known.store_value = 16'h0000;
    rows.push_back('{make_instr(OP_REM, 16'h8000, 16'hffff, 0, 0, 2), 1'b1, known});
    known.store_value = 16'h0000;
    rows.push_back('{make_instr(OP_ADD, 16'hffff, 16'h0001, 0, 0, 2), 1'b1, known});
    known = '0;
    rows.push_back('{make_instr(OP_UNUSED, 16'hffff, 16'hffff, '1, '1, '1), 1'b1, known});
    rows.push_back('{make_instr(OP_SUB, 0, 1, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_MUL, 16'hffff, 16'hffff, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_DIV, 16'hfff9, 16'h0002, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_REM, 16'hfff9, 16'h0002, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_SHIFT, 16'hffff, 16'd16, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_SHIFT, 16'h8001, 16'hffff, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_SHIFT, 16'h8001, 16'hfff0, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_ASHIFT, 16'h8001, 16'hfff0, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_ASHIFT, 16'h8001, 16'hfffc, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_ASHIFT, 16'h1234, 16'h0000, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_OR, 16'hf0f0, 16'h0ff0, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_NOT, 16'h0000, 16'h0000, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_AND, 16'hf0f0, 16'h0ff0, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_TEST, 16'hf0f0, 16'h00f0, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_JZ, 16'h0000, 16'h0000, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_JE, 16'h0005, 16'h0001, 16'h0002, 16'h0005, 3'd4),
                     1'b0, known});
    rows.push_back('{make_instr(OP_JE, 16'h0005, 16'h0001, 16'h0002, 16'h0005, 3'd7),
                     1'b0, known});
    rows.push_back('{make_instr(OP_JE, 16'h0005, 16'h0005, 0, 0, 3'd1), 1'b0, known});
    rows.push_back('{make_instr(OP_JL, 16'h8000, 16'h7fff, 0, 0, 2), 1'b0, known});
    rows.push_back('{make_instr(OP_JG, 16'h8000, 16'h7fff, 0, 0, 2), 1'b0, known});

    foreach (rows[i]) begin
      row = rows[i];
      if (row.check_row && alu_result(row.instr) != row.row_result) begin
        $error("table row %0d: store_value expected %h, model gives %h", i,
               row.row_result.store_value, alu_result(row.instr).store_value);
        errors++;
      end
      send_beat(row.instr);
    end
    in_ch.valid <= 1'b0;

    // Hold off until the pipe drains once
    while (pending_results.size() != 0) @(posedge clk);

    for (int k = 0; k < RandomBeats; k++) begin
      x.op = OpBits'($urandom_range(0, 15));
      x.operand_a = rand_word();
      x.operand_b = rand_word();
      x.operand_c = ($urandom_range(0, 2) == 0) ? x.operand_a : rand_word();
      x.operand_d = ($urandom_range(0, 2) == 0) ? x.operand_a : rand_word();
      x.operand_count = CntBits'($urandom_range(0, 7));
      if (x.op == OP_JE && $urandom_range(0, 2) == 0) x.operand_b = x.operand_a;
      send_beat(x);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Drain and report
  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("** zmachine_alu_and_compare: PASSED **");
    end else begin
      $display("** zmachine_alu_and_compare: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/zac_pkg.sv
rtl/zac_if.sv
rtl/zac_divider.sv
rtl/zmachine_alu_and_compare.sv
test/testbench.sv
